[sv/lpcp_pkg.sv]
package lpcp_pkg;

   localparam int ID_W        = 16;
   localparam int COORD_W     = 32;
   localparam int COEF_W      = 32;
   localparam int PAIR_W      = 64;
   localparam int NUM_PAIRS   = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_DATA_W  = ID_W + 3 * COORD_W;
   localparam int RSP_DATA_W  = ID_W + 3 * COORD_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PAIR_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PAIR_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PAIR_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PAIR_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PAIR_4 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_PAIR_5 = 3'd5;

   localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] coef_bank_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Width of a row sum: three floored products plus one coefficient.
   function automatic int sum_width(int frac_bits);
      return 66 - frac_bits;
   endfunction

   // Queue entry: depth, row 1, row 0, height, id from the top bit down.
   function automatic int payload_width(int frac_bits);
      return ID_W + COORD_W + 3 * sum_width(frac_bits);
   endfunction

endpackage

[sv/lpcp_fifo.sv]
module lpcp_fifo #(
   parameter int WIDTH = 186,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output lpcp_pkg::fifo_status_type  status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("Queue written while full.");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("Queue read while empty.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Queue count beyond depth.");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !status.empty)
      else $error("Queue empty after a lone write.");

endmodule

[sv/lpcp_front.sv]
module lpcp_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lpcp_pkg::coef_bank_type                coef,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [lpcp_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  lpcp_pkg::fifo_status_type              fifo_status,
   output logic                                   push,
   output logic [lpcp_pkg::payload_width(FRAC_BITS)-1:0] push_data
);

   localparam int SUM_W = lpcp_pkg::sum_width(FRAC_BITS);
   localparam int CW    = lpcp_pkg::COORD_W;

   logic                           en;
   logic signed [CW-1:0]           coord [0:2];
   logic                           s1_vld_ff, s1_vld_in;
   logic signed [2*CW-1:0]         prod_ff [0:2][0:2];
   logic signed [2*CW-1:0]         prod_in [0:2][0:2];
   logic [lpcp_pkg::COEF_W-1:0]    c3_ff [0:2];
   logic [lpcp_pkg::COEF_W-1:0]    c3_in [0:2];
   logic [lpcp_pkg::ID_W-1:0]      id1_ff;
   logic [CW-1:0]                  z1_ff;
   logic                           s2_vld_ff, s2_vld_in;
   logic [SUM_W-1:0]               sum_ff [0:2];
   logic [SUM_W-1:0]               sum_in [0:2];
   logic [lpcp_pkg::ID_W-1:0]      id2_ff;
   logic [CW-1:0]                  z2_ff;

   assign en         = !(s2_vld_ff && fifo_status.full);
   assign req_tready = en;

   assign coord[0] = req_tdata[47:16];
   assign coord[1] = req_tdata[79:48];
   assign coord[2] = req_tdata[111:80];

   // A point behind the sensor is taken and dropped at once.
   assign s1_vld_in = req_tvalid && !coord[0][CW-1];
   assign s2_vld_in = s1_vld_ff;

   always_comb begin
      logic signed [lpcp_pkg::COEF_W-1:0] cw;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cw = coef[r * 2 + (c >> 1)][(c & 1) * lpcp_pkg::COEF_W +: lpcp_pkg::COEF_W];
            prod_in[r][c] = cw * coord[c];
         end
         c3_in[r] = coef[r * 2 + 1][lpcp_pkg::COEF_W +: lpcp_pkg::COEF_W];
      end
   end

   always_comb begin
      logic [SUM_W-1:0] t [0:2];
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            t[c] = {{2{prod_ff[r][c][2*CW-1]}}, prod_ff[r][c][2*CW-1:FRAC_BITS]};
         end
         sum_in[r] = t[0] + t[1] + t[2]
                   + {{(SUM_W - lpcp_pkg::COEF_W){c3_ff[r][lpcp_pkg::COEF_W-1]}}, c3_ff[r]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= prod_in[r][c];
            end
            c3_ff[r]  <= c3_in[r];
            sum_ff[r] <= sum_in[r];
         end
         id1_ff <= req_tdata[15:0];
         z1_ff  <= coord[2];
         id2_ff <= id1_ff;
         z2_ff  <= z1_ff;
      end
   end

   // A point behind the camera (negative depth) is dropped here.
   assign push      = s2_vld_ff && !sum_ff[2][SUM_W-1] && !fifo_status.full;
   assign push_data = {sum_ff[2], sum_ff[1], sum_ff[0], z2_ff, id2_ff};

endmodule

[sv/lpcp_back.sv]
module lpcp_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lpcp_pkg::fifo_status_type              fifo_status,
   output logic                                   pop,
   input  logic [lpcp_pkg::payload_width(FRAC_BITS)-1:0] pop_data,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [lpcp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tuser
);

   localparam int SUM_W = lpcp_pkg::sum_width(FRAC_BITS);
   localparam int CW    = lpcp_pkg::COORD_W;
   localparam int DIV_W = SUM_W + CW;
   localparam int NSTG  = CW;

   typedef struct packed {
      logic [lpcp_pkg::ID_W-1:0] id;
      logic [CW-1:0]             z;
      logic [1:0]                neg;
      logic [1:0]                nz;
      logic [1:0]                ov;
      logic                      zero;
   } side_type;

   logic                en;
   logic [SUM_W-1:0]    r_in [0:1];
   logic [SUM_W-1:0]    w_in;

   logic                vld_ff [0:NSTG];
   logic                vld_in [0:NSTG];
   logic [DIV_W-1:0]    rem_ff [0:1][0:NSTG];
   logic [DIV_W-1:0]    rem_in [0:1][0:NSTG];
   logic [CW-1:0]       q_ff [0:1][0:NSTG];
   logic [CW-1:0]       q_in [0:1][0:NSTG];
   logic [SUM_W-1:0]    d_ff [0:NSTG];
   logic [SUM_W-1:0]    d_in [0:NSTG];
   side_type            side_ff [0:NSTG];
   side_type            side_in [0:NSTG];

   logic                out_vld_ff, out_vld_in;
   logic [CW-1:0]       out_val_ff [0:1];
   logic [CW-1:0]       out_val_in [0:1];
   logic                out_sat_ff, out_sat_in;
   logic [lpcp_pkg::ID_W-1:0] out_id_ff;
   logic [CW-1:0]       out_z_ff;

   assign en  = !out_vld_ff || rsp_tready;
   assign pop = en && !fifo_status.empty;

   assign r_in[0] = pop_data[lpcp_pkg::ID_W + CW +: SUM_W];
   assign r_in[1] = pop_data[lpcp_pkg::ID_W + CW + SUM_W +: SUM_W];
   assign w_in    = pop_data[lpcp_pkg::ID_W + CW + 2 * SUM_W +: SUM_W];

   // Entry stage: magnitudes, signs and the early overflow test.
   always_comb begin
      logic [SUM_W-1:0] mag;
      logic [DIV_W-1:0] dsh;
      logic             ge;
      vld_in[0]       = pop;
      d_in[0]         = w_in;
      side_in[0].id   = pop_data[lpcp_pkg::ID_W-1:0];
      side_in[0].z    = pop_data[lpcp_pkg::ID_W +: CW];
      side_in[0].zero = (w_in == '0);
      for (int i = 0; i < 2; i++) begin
         side_in[0].neg[i] = r_in[i][SUM_W-1];
         side_in[0].nz[i]  = |r_in[i];
         mag = r_in[i][SUM_W-1] ? (~r_in[i]) + SUM_W'(1) : r_in[i];
         side_in[0].ov[i] = ({{CW{1'b0}}, mag} >= ({{CW{1'b0}}, w_in} << (CW - FRAC_BITS)));
         rem_in[i][0]     = {{CW{1'b0}}, mag} << FRAC_BITS;
         q_in[i][0]       = '0;
      end
      // Restoring division, one quotient bit per stage, most significant first.
      for (int j = 0; j < NSTG; j++) begin
         vld_in[j+1]  = vld_ff[j];
         d_in[j+1]    = d_ff[j];
         side_in[j+1] = side_ff[j];
         dsh = {{CW{1'b0}}, d_ff[j]} << (NSTG - 1 - j);
         for (int i = 0; i < 2; i++) begin
            ge              = (rem_ff[i][j] >= dsh);
            rem_in[i][j+1]  = ge ? rem_ff[i][j] - dsh : rem_ff[i][j];
            q_in[i][j+1]    = {q_ff[i][j][CW-2:0], ge};
         end
      end
   end

   always_comb begin
      logic [CW-1:0] limit;
      side_type      s;
      s          = side_ff[NSTG];
      out_vld_in = vld_ff[NSTG];
      out_sat_in = s.zero;
      for (int i = 0; i < 2; i++) begin
         limit = s.neg[i] ? lpcp_pkg::NEG_LIMIT : lpcp_pkg::POS_LIMIT;
         if (s.zero) begin
            out_val_in[i] = s.nz[i] ? limit : '0;
         end else if (s.ov[i] || (q_ff[i][NSTG] > limit)) begin
            out_val_in[i] = limit;
            out_sat_in    = 1'b1;
         end else begin
            out_val_in[i] = s.neg[i] ? (~q_ff[i][NSTG]) + CW'(1) : q_ff[i][NSTG];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NSTG; j++) begin
            vld_ff[j] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (en) begin
         for (int j = 0; j <= NSTG; j++) begin
            vld_ff[j] <= vld_in[j];
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= NSTG; j++) begin
            d_ff[j]    <= d_in[j];
            side_ff[j] <= side_in[j];
            for (int i = 0; i < 2; i++) begin
               rem_ff[i][j] <= rem_in[i][j];
               q_ff[i][j]   <= q_in[i][j];
            end
         end
         out_val_ff[0] <= out_val_in[0];
         out_val_ff[1] <= out_val_in[1];
         out_sat_ff    <= out_sat_in;
         out_id_ff     <= side_ff[NSTG].id;
         out_z_ff      <= side_ff[NSTG].z;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_z_ff, out_val_ff[1], out_val_ff[0], out_id_ff};
   assign rsp_tuser  = out_sat_ff;

endmodule

[sv/lidar_point_camera_projection.sv]
// Projects lidar points (id, x, y, z in signed fixed point with FRAC_BITS fraction bits)
// through a 3x4 matrix held in six 64-bit coefficient registers and returns
// u = row0 / depth and v = row1 / depth with the id and z passed through. Points with
// negative x or negative depth give no result; zero depth or a clipped quotient sets
// the saturated flag. The block takes one point per cycle while the queue is not full and
// returns one result per cycle when the output is not stalled; a point passes through
// the two-stage multiply and sum front end, the four-entry queue, and the 32-stage
// restoring divider that forms one quotient bit per stage for u and v side by side.
module lidar_point_camera_projection #(
   parameter int FRAC_BITS  = 16,
   parameter int FIFO_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // cluster_id, x_coord, y_coord, z_coord
   input  logic [lpcp_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // id_out, u_pixel, v_pixel, height_out
   output logic [lpcp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // saturated
   output logic                                  rsp_tuser,
   input  logic                                  csr_wr_en,
   input  logic [lpcp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lpcp_pkg::PAIR_W-1:0]           csr_wdata
);

   localparam int PAY_W = lpcp_pkg::payload_width(FRAC_BITS);

   lpcp_pkg::coef_bank_type   coef_ff, coef_in;
   lpcp_pkg::fifo_status_type fifo_status;
   logic                      push;
   logic [PAY_W-1:0]          push_data;
   logic                      pop;
   logic [PAY_W-1:0]          pop_data;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lpcp_pkg::CSR_COEF_PAIR_0: coef_in[0] = csr_wdata;
            lpcp_pkg::CSR_COEF_PAIR_1: coef_in[1] = csr_wdata;
            lpcp_pkg::CSR_COEF_PAIR_2: coef_in[2] = csr_wdata;
            lpcp_pkg::CSR_COEF_PAIR_3: coef_in[3] = csr_wdata;
            lpcp_pkg::CSR_COEF_PAIR_4: coef_in[4] = csr_wdata;
            lpcp_pkg::CSR_COEF_PAIR_5: coef_in[5] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   lpcp_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .coef        (coef_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data)
   );

   lpcp_fifo #(
      .WIDTH (PAY_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   lpcp_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop         (pop),
      .pop_data    (pop_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
